@@ hdl/remote_login_line_editor_macros.svh @@
// Assertion shorthands for the line editor; all sample on i_clk and
// are held off while i_rst_n is low.
`ifndef REMOTE_LOGIN_LINE_EDITOR_MACROS_SVH
`define REMOTE_LOGIN_LINE_EDITOR_MACROS_SVH

// condition must hold at every edge
`define RLE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rle_pkg.sv @@
`default_nettype none
package rle_pkg;

    // line buffer geometry
    localparam int LINE_DEPTH = 32;
    localparam int CntW       = $clog2(LINE_DEPTH + 1);
    localparam int AddrW      = $clog2(LINE_DEPTH);
    localparam int StepW      = 3;

    // special bytes
    localparam logic [7:0] K_FF   = 8'hFF;
    localparam logic [7:0] K_BS   = 8'h08;
    localparam logic [7:0] K_DEL  = 8'h7F;
    localparam logic [7:0] K_INT  = 8'h03;
    localparam logic [7:0] K_KILL = 8'h15;
    localparam logic [7:0] K_CR   = 8'h0D;
    localparam logic [7:0] K_LF   = 8'h0A;
    localparam logic [7:0] K_SP   = 8'h20;
    localparam logic [7:0] K_X    = 8'h58;

    // window-size message body length
    localparam logic [3:0] MSG_SKIP = 4'd10;

    typedef enum logic [1:0] {
        DEST_ECHO  = 2'd0,
        DEST_SHELL = 2'd1,
        DEST_INT   = 2'd2
    } t_dest;

    // what an accepted byte turns into
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_ERASE,
        CLS_INT,
        CLS_KILL,
        CLS_ORD,
        CLS_CR
    } t_cls;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIXED,
        S_LINE_RD,
        S_LINE_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit_fixed;
        logic emit_line;
    } t_cmd;

    typedef struct packed {
        t_cls cls_in;
        logic out_free;
        logic step_last;
        logic cr_head_done;
        logic line_empty;
        logic line_next_done;
    } t_sts;

    typedef struct packed {
        t_dest      dest;
        logic [7:0] data;
    } t_res;

    // index of the final fixed step for a class; CR ends on its shell LF
    function automatic logic [StepW-1:0] rle_fixed_last(input t_cls cls);
        logic [StepW-1:0] v;
        case (cls)
            CLS_ERASE: v = StepW'(2);
            CLS_KILL:  v = StepW'(5);
            CLS_CR:    v = StepW'(3);
            default:   v = StepW'(0);
        endcase
        return v;
    endfunction

    // fixed result for each step of a class
    function automatic t_res rle_fixed(input t_cls cls, input logic [StepW-1:0] step,
                                       input logic [7:0] b);
        t_res r;
        r.dest = DEST_ECHO;
        r.data = 8'h00;
        case (cls)
            CLS_ERASE: begin
                r.data = (step == StepW'(1)) ? K_SP : K_BS;
            end
            CLS_INT: begin
                r.dest = DEST_INT;
            end
            CLS_KILL: begin
                case (step) inside
                    StepW'(0):              r.data = K_SP;
                    [StepW'(1):StepW'(3)]:  r.data = K_X;
                    StepW'(4):              r.data = K_CR;
                    default:                r.data = K_LF;
                endcase
            end
            CLS_ORD: begin
                r.data = b;
            end
            CLS_CR: begin
                case (step)
                    StepW'(0): r.data = K_CR;
                    StepW'(1): r.data = K_LF;
                    StepW'(2): begin
                        r.dest = DEST_SHELL;
                        r.data = K_CR;
                    end
                    default: begin
                        r.dest = DEST_SHELL;
                        r.data = K_LF;
                    end
                endcase
            end
            default: r.data = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/remote_login_line_editor.sv @@
// A taken byte is classed into a register; its first result is then built in
// the output register. Fixed echoes and the trailing CR LF go out one per cycle
// while the output is not stalled; each line byte of a CR flush passes a read
// state and an output state, for the registered read of the line store. One
// byte in flight: the input is stalled until a byte's last result is built.
// Reset (i_rst_n low, synchronous) empties the line and clears the message
// counters; the line store itself is not cleared.
`default_nettype none
`include "remote_login_line_editor_macros.svh"
module remote_login_line_editor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_dest,
    output logic [7:0]      o_data,
    output logic            o_last
);
    import rle_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    rle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    // line store, counters and output register
    rle_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_rx_byte (i_rx_byte),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_dest    (o_dest),
        .o_data    (o_data),
        .o_last    (o_last)
    );

    // a result is never built over one still waiting
    `RLE_ASSERT_IMP(a_emit_free, w_cmd.emit_fixed || w_cmd.emit_line, w_sts.out_free, "emit while output busy")
    `RLE_ASSERT(a_emit_one, !(w_cmd.emit_fixed && w_cmd.emit_line), "two emits at once")
    `RLE_ASSERT_NXT(a_last_flag, w_cmd.emit_fixed && w_sts.step_last, o_valid && o_last, "final transfer lost its last flag")
    `RLE_ASSERT_NXT(a_quiet_byte, w_cmd.accept && w_sts.cls_in == CLS_NONE, !o_stall, "byte without result held the input")

endmodule
`default_nettype wire

@@ hdl/rle_ctrl.sv @@
`default_nettype none
module rle_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  rle_pkg::t_sts      i_sts,
    output rle_pkg::t_cmd      o_cmd,
    output logic               o_stall
);
    import rle_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.cls_in != CLS_NONE) begin
                        n_state = S_FIXED;
                    end
                end
            end
            S_FIXED: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_fixed = 1'b1;
                    if (i_sts.step_last) begin
                        n_state = S_IDLE;
                    end else if (i_sts.cr_head_done && !i_sts.line_empty) begin
                        n_state = S_LINE_RD;
                    end
                end
            end
            S_LINE_RD: begin
                // read data lands at the end of this cycle
                n_state = S_LINE_OUT;
            end
            S_LINE_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_line = 1'b1;
                    n_state = i_sts.line_next_done ? S_FIXED : S_LINE_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/rle_dp.sv @@
`default_nettype none
module rle_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  rle_pkg::t_cmd      i_cmd,
    output rle_pkg::t_sts      o_sts,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [1:0]         o_dest,
    output logic [7:0]         o_data,
    output logic               o_last
);
    import rle_pkg::*;

    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;
    logic [3:0]       r_skip;
    logic [3:0]       n_skip;
    logic             r_saw_ff;
    logic             n_saw_ff;
    t_cls             r_cls;
    t_cls             w_cls;
    logic             w_store;
    logic [StepW-1:0] r_step;
    logic [7:0]       r_byte;
    logic [CntW-1:0]  r_idx;
    logic [7:0]       r_rd;
    logic             r_out_valid;
    t_dest            r_dest;
    logic [7:0]       r_data;
    logic             r_last;
    logic [7:0]       mem [LINE_DEPTH];
    t_res             w_fix;
    logic             w_step_last;
    logic             w_room;

    // room for the byte plus a trailing CR LF
    assign w_room = ((CntW + 1)'(r_count) + (CntW + 1)'(3)) <= (CntW + 1)'(LINE_DEPTH);

    // classify the incoming byte and work out the state it leaves
    always_comb begin
        n_count  = r_count;
        n_skip   = r_skip;
        n_saw_ff = r_saw_ff;
        w_cls    = CLS_NONE;
        w_store  = 1'b0;
        if (r_skip != 4'd0) begin
            n_skip = r_skip - 4'd1;
        end else if (i_rx_byte == K_FF) begin
            if (r_saw_ff) begin
                n_skip   = MSG_SKIP;
                n_saw_ff = 1'b0;
            end else begin
                n_saw_ff = 1'b1;
            end
        end else begin
            n_saw_ff = 1'b0;
            case (i_rx_byte) inside
                K_BS, K_DEL: begin
                    if (r_count != '0) begin
                        w_cls   = CLS_ERASE;
                        n_count = r_count - CntW'(1);
                    end
                end
                K_INT: w_cls = CLS_INT;
                K_KILL: begin
                    w_cls   = CLS_KILL;
                    n_count = '0;
                end
                K_CR: w_cls = CLS_CR;
                default: begin
                    if (w_room) begin
                        w_cls   = CLS_ORD;
                        w_store = 1'b1;
                        n_count = r_count + CntW'(1);
                    end
                end
            endcase
        end
    end

    assign w_fix       = rle_fixed(r_cls, r_step, r_byte);
    assign w_step_last = (r_step == rle_fixed_last(r_cls));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_skip      <= '0;
            r_saw_ff    <= 1'b0;
            r_cls       <= CLS_NONE;
            r_step      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_count  <= n_count;
                r_skip   <= n_skip;
                r_saw_ff <= n_saw_ff;
                r_cls    <= w_cls;
                r_step   <= '0;
                r_idx    <= '0;
            end
            if (i_cmd.emit_fixed) begin
                r_step <= r_step + StepW'(1);
                // a flushed line is cleared after its final transfer is built
                if (w_step_last && r_cls == CLS_CR) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.emit_line) begin
                r_idx <= r_idx + CntW'(1);
            end
            if (i_cmd.emit_fixed || i_cmd.emit_line) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line store: one write port, registered read at the walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_store) begin
            mem[r_count[AddrW-1:0]] <= i_rx_byte;
        end
        r_rd <= mem[r_idx[AddrW-1:0]];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.emit_fixed) begin
            r_dest <= w_fix.dest;
            r_data <= w_fix.data;
            r_last <= w_step_last;
        end else if (i_cmd.emit_line) begin
            r_dest <= DEST_SHELL;
            r_data <= r_rd;
            r_last <= 1'b0;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.cls_in         = w_cls;
        o_sts.out_free       = !r_out_valid || !i_stall;
        o_sts.step_last      = w_step_last;
        o_sts.cr_head_done   = (r_cls == CLS_CR) && (r_step == StepW'(1));
        o_sts.line_empty     = (r_count == '0);
        o_sts.line_next_done = ((r_idx + CntW'(1)) == r_count);
    end

    assign o_valid = r_out_valid;
    assign o_dest  = r_dest;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rle_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int RANDOM_ITEMS = 420;
    localparam int DRAIN_CYCLES = 40;

    // opening sequence: erase on an empty line, byte extremes, every control,
    // a lone 0xFF, then a window-size message whose body holds every control
    localparam logic [7:0] OPENING [26] = '{
        K_BS, K_DEL, 8'h00, 8'hFE, 8'h61, K_DEL, K_BS, K_INT, 8'h71, K_KILL,
        K_CR, K_FF, 8'h7A, K_CR, K_FF, K_FF,
        K_FF, K_CR, K_INT, K_KILL, K_BS, K_DEL, 8'h00, 8'h41, 8'h42, 8'h43
    };

    typedef struct {
        t_dest      dest;
        logic [7:0] data;
        logic       last;
    } line_result_t;

    // Tracks the editor state and the results each received byte is due to cause.
    class line_editor_scoreboard;
        line_result_t due_output[$];
        logic [7:0]   line_buf [LINE_DEPTH];
        int           line_len;
        logic [3:0]   skip_left;
        bit           ff_pending;
        int           errors;
        int           n_bytes;
        int           active_items;
        int           n_checked;
        int           n_flushes;
        int           n_full_drops;

        function new();
            line_len     = 0;
            skip_left    = '0;
            ff_pending   = 1'b0;
            errors       = 0;
            n_bytes      = 0;
            active_items = 0;
            n_checked    = 0;
            n_flushes    = 0;
            n_full_drops = 0;
        endfunction

        function void queue_result(t_dest d, logic [7:0] v);
            line_result_t r;
            r.dest = d;
            r.data = v;
            r.last = 1'b0;
            due_output.push_back(r);
        endfunction

        // one accepted byte: update the line state and queue its results
        function void take_rx_byte(logic [7:0] b);
            int           old_size;
            line_result_t tail;
            old_size = due_output.size();
            n_bytes++;
            // inside a window-size message body
            if (skip_left != 4'd0) begin
                skip_left--;
                return;
            end
            if (b == K_FF) begin
                if (ff_pending) begin
                    skip_left  = MSG_SKIP;
                    ff_pending = 1'b0;
                end else begin
                    ff_pending = 1'b1;
                end
                return;
            end
            ff_pending = 1'b0;

            if (b == K_BS || b == K_DEL) begin
                if (line_len > 0) begin
                    line_len--;
                    queue_result(DEST_ECHO, K_BS);
                    queue_result(DEST_ECHO, K_SP);
                    queue_result(DEST_ECHO, K_BS);
                end
            end else if (b == K_INT) begin
                queue_result(DEST_INT, 8'h00);
            end else if (b == K_KILL) begin
                line_len = 0;
                queue_result(DEST_ECHO, K_SP);
                repeat (3) queue_result(DEST_ECHO, K_X);
                queue_result(DEST_ECHO, K_CR);
                queue_result(DEST_ECHO, K_LF);
            end else if (b == K_CR) begin
                queue_result(DEST_ECHO, K_CR);
                queue_result(DEST_ECHO, K_LF);
                for (int i = 0; i < line_len; i++)
                    queue_result(DEST_SHELL, line_buf[i]);
                queue_result(DEST_SHELL, K_CR);
                queue_result(DEST_SHELL, K_LF);
                line_len = 0;
                n_flushes++;
            end else if (line_len + 3 <= LINE_DEPTH) begin
                line_buf[line_len] = b;
                line_len++;
                queue_result(DEST_ECHO, b);
            end else begin
                // keep room for the CR LF
                n_full_drops++;
            end

            if (due_output.size() > old_size) begin
                tail = due_output.pop_back();
                tail.last = 1'b1;
                due_output.push_back(tail);
                active_items++;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 50)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        // one result transfer against the oldest due result
        task check_output(logic [1:0] dest, logic [7:0] data, logic last);
            line_result_t want;
            if (due_output.size() == 0) begin
                report_mismatch($sformatf("unexpected result dest=%0d data=%02h last=%0b",
                                          dest, data, last));
                return;
            end
            want = due_output.pop_front();
            n_checked++;
            if (dest !== want.dest)
                report_mismatch($sformatf("result %0d: dest %0d, want %0d",
                                          n_checked, dest, want.dest));
            if (data !== want.data)
                report_mismatch($sformatf("result %0d: data %02h, want %02h",
                                          n_checked, data, want.data));
            if (last !== want.last)
                report_mismatch($sformatf("result %0d: last %0b, want %0b",
                                          n_checked, last, want.last));
        endtask
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_dest;
    logic [7:0] o_data;
    logic       o_last;

    line_editor_scoreboard sb = new();
    int idle_pct = 29;
    int cycles   = 0;
    int pick;

    remote_login_line_editor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_rx_byte(i_rx_byte),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_dest   (o_dest),
        .o_data   (o_data),
        .o_last   (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycles, sb.due_output.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check each transfer, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0)
            sb.check_output(o_dest, o_data, o_last);
        i_stall <= ($urandom_range(99) < idle_pct);
    end

    // byte that is neither a control code nor 0xFF, mostly printable
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        do begin
            if ($urandom_range(99) < 70)
                b = 8'($urandom_range(8'h7E, 8'h20));
            else
                b = 8'($urandom_range(255));
        end while (b == K_FF || b == K_BS || b == K_DEL || b == K_INT ||
                   b == K_KILL || b == K_CR);
        return b;
    endfunction

    // one input transfer, after a random idle gap
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        sb.take_rx_byte(b);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING[k]) send_byte(OPENING[k]);

        // random sessions: mostly well-formed typing, plus noise
        while (sb.n_bytes < RANDOM_ITEMS) begin
            idle_pct = (sb.n_bytes >= 150 && sb.n_bytes < 250) ? 0 : 29;
            pick = $urandom_range(99);
            if (pick < 40) begin
                // a typed word with the odd correction, usually ended by CR
                repeat ($urandom_range(12, 1)) begin
                    send_byte(pick_plain());
                    if ($urandom_range(99) < 15)
                        send_byte($urandom_range(1) ? K_BS : K_DEL);
                end
                if ($urandom_range(99) < 80) send_byte(K_CR);
            end else if (pick < 47) begin
                // overfill the line, then flush it
                repeat (LINE_DEPTH + $urandom_range(4)) send_byte(pick_plain());
                if ($urandom_range(1)) send_byte(K_DEL);
                send_byte(K_CR);
            end else if (pick < 57) begin
                repeat ($urandom_range(6, 1)) begin
                    send_byte(pick_plain());
                    send_byte($urandom_range(1) ? K_BS : K_DEL);
                    if ($urandom_range(1)) send_byte(K_BS);
                end
            end else if (pick < 63) begin
                repeat ($urandom_range(5)) send_byte(pick_plain());
                send_byte(K_KILL);
            end else if (pick < 73) begin
                // window-size message with an arbitrary body
                send_byte(K_FF);
                send_byte(K_FF);
                repeat (10) send_byte(8'($urandom_range(255)));
                send_byte(pick_plain());
            end else if (pick < 79) begin
                send_byte(K_FF);
                send_byte($urandom_range(1) ? pick_plain() : K_CR);
            end else if (pick < 85) begin
                send_byte(K_INT);
            end else begin
                repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
            end
        end
        i_valid <= 1'b0;

        while (sb.due_output.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Line editor: %0d bytes in (%0d with results), %0d results checked",
                 sb.n_bytes, sb.active_items, sb.n_checked);
        $display("  %0d lines flushed, %0d bytes dropped on a full line, %0d mismatches",
                 sb.n_flushes, sb.n_full_drops, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
